>>> rtl/ctu_pkg.sv
// ============================================================================
// ctu_pkg
// Shared types, constants and the month table of the civil time converter.
// ============================================================================
package ctu_pkg;

    localparam int unsigned YearMin     = 1970;
    localparam int unsigned YearMax     = 2200;
    // Years are counted from 1968, the last leap year before the epoch.
    localparam int unsigned YearBase    = 1968;
    localparam int unsigned CenturyA    = 2100;
    localparam int unsigned CenturyB    = 2200;
    // Day count bias: 719468 minus 365*1968 and the leap days up to 1968.
    localparam int unsigned DayBias     = 671;
    localparam int unsigned DaysPerYear = 365;
    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin  = 60;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic        offset_negative;
        logic [6:0]  offset_hours;
        logic [6:0]  offset_minutes;
    } t_in_word;

    typedef struct packed {
        logic signed [33:0] unix_seconds;
        logic               valid_res;
    } t_out_word;

    // After field decode.
    typedef struct packed {
        logic        ok;
        logic [7:0]  year_ofs;
        logic [1:0]  century_cnt;
        logic [8:0]  day_of_year;
        logic [16:0] time_of_day;
        logic        off_neg;
        logic [18:0] off_mag;
    } t_dec;

    // After day count.
    typedef struct packed {
        logic               ok;
        logic [16:0]        days;
        logic signed [20:0] sec_adj;
    } t_days;

    // After scaling days to seconds.
    typedef struct packed {
        logic               ok;
        logic [32:0]        day_secs;
        logic signed [20:0] sec_adj;
    } t_scaled;

    // Days from March 1 to the first day of the month, year starting in March.
    function automatic logic [8:0] month_base(input logic [3:0] month);
        logic [8:0] base;
        case (month)
            4'd3:    base = 9'd0;
            4'd4:    base = 9'd31;
            4'd5:    base = 9'd61;
            4'd6:    base = 9'd92;
            4'd7:    base = 9'd122;
            4'd8:    base = 9'd153;
            4'd9:    base = 9'd184;
            4'd10:   base = 9'd214;
            4'd11:   base = 9'd245;
            4'd12:   base = 9'd275;
            4'd1:    base = 9'd306;
            4'd2:    base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

>>> rtl/civil_time_to_unix_seconds.sv
// ============================================================================
// civil_time_to_unix_seconds
// Converts a split civil timestamp with zone offset to signed Unix seconds.
// ============================================================================
// Usage:
// The input channel (i_in_valid, o_in_ready, i_in_data) takes one timestamp
// word: year, month, day, hour, minute, second and the zone offset. The
// output channel (o_out_valid, i_out_ready, o_out_data) returns one word per
// input: Unix seconds and a flag that is set when all date and time fields
// were in range. An out-of-range word gives zero seconds with the flag clear.
// An accepted word passes four registered stages to o_out_valid: field
// decode, day count, the 17 by 17 bit days-to-seconds multiply in a stage
// of its own, and the final sum in the output register. Throughput is one
// word per cycle unless the output stalls; each stage has its own valid bit.
// When the receiver holds i_out_ready low, the output word stays put and the
// stages behind it keep filling until all four are full; then o_in_ready
// drops. Nothing is lost or repeated. Synchronous reset empties every stage
// and leaves o_in_ready high.
// ============================================================================
module civil_time_to_unix_seconds (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ctu_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ctu_pkg::t_out_word o_out_data
);

    logic           dec_valid;
    logic           dec_ready;
    ctu_pkg::t_dec  dec_data;
    logic           days_valid;
    logic           days_ready;
    ctu_pkg::t_days days_data;

    ctu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (dec_valid),
        .i_ready (dec_ready),
        .o_data  (dec_data)
    );

    ctu_days u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_data  (dec_data),
        .o_valid (days_valid),
        .i_ready (days_ready),
        .o_data  (days_data)
    );

    ctu_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (days_valid),
        .o_ready (days_ready),
        .i_data  (days_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

>>> rtl/ctu_decode.sv
// ============================================================================
// ctu_decode
// First stage: range checks, year offset, day of year, time of day, offset.
// ============================================================================
module ctu_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ctu_pkg::t_in_word i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output ctu_pkg::t_dec     o_data
);

    logic          r_valid;
    ctu_pkg::t_dec r_data;
    ctu_pkg::t_dec n_data;
    logic          early_month;
    logic [13:0]   adj_year;
    logic          ok;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        ok = (i_data.year >= 14'(ctu_pkg::YearMin)) && (i_data.year <= 14'(ctu_pkg::YearMax))
            && (i_data.month >= 7'd1) && (i_data.month <= 7'd12)
            && (i_data.day >= 7'd1) && (i_data.day <= 7'd31)
            && (i_data.hour <= 7'd23) && (i_data.minute <= 7'd59)
            && (i_data.second <= 7'd60);
        // January and February count with the previous year.
        early_month = (i_data.month <= 7'd2);
        adj_year    = i_data.year - 14'(early_month);

        n_data.ok          = ok;
        n_data.year_ofs    = 8'(adj_year - 14'(ctu_pkg::YearBase));
        n_data.century_cnt = 2'(adj_year >= 14'(ctu_pkg::CenturyA))
                           + 2'(adj_year >= 14'(ctu_pkg::CenturyB));
        n_data.day_of_year = ctu_pkg::month_base(i_data.month[3:0])
                           + 9'(i_data.day) - 9'd1;
        n_data.time_of_day = 17'(i_data.hour) * 17'(ctu_pkg::SecsPerHour)
                           + 17'(i_data.minute) * 17'(ctu_pkg::SecsPerMin)
                           + 17'(i_data.second);
        n_data.off_neg     = i_data.offset_negative;
        n_data.off_mag     = 19'(i_data.offset_hours) * 19'(ctu_pkg::SecsPerHour)
                           + 19'(i_data.offset_minutes) * 19'(ctu_pkg::SecsPerMin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/ctu_days.sv
// ============================================================================
// ctu_days
// Second stage: days since the epoch and the signed intra-day second count.
// ============================================================================
module ctu_days (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ctu_pkg::t_dec  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ctu_pkg::t_days o_data
);

    logic           r_valid;
    ctu_pkg::t_days r_data;
    ctu_pkg::t_days n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // Leap days: every fourth year, less the non-leap centuries 2100 and 2200.
        n_data.ok   = i_data.ok;
        n_data.days = 17'(i_data.year_ofs) * 17'(ctu_pkg::DaysPerYear)
                    + 17'(i_data.year_ofs[7:2])
                    + 17'(i_data.day_of_year)
                    - 17'(i_data.century_cnt)
                    - 17'(ctu_pkg::DayBias);
        // The zone offset is subtracted, so a negative offset adds.
        if (i_data.off_neg) begin
            n_data.sec_adj = signed'(21'(i_data.time_of_day) + 21'(i_data.off_mag));
        end else begin
            n_data.sec_adj = signed'(21'(i_data.time_of_day) - 21'(i_data.off_mag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/ctu_combine.sv
// ============================================================================
// ctu_combine
// Third and fourth stages: days times 86400, then the final sum and the
// output register that holds the word for the receiver.
// ============================================================================
module ctu_combine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ctu_pkg::t_days     i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output ctu_pkg::t_out_word o_data
);

    logic               r_mul_valid;
    ctu_pkg::t_scaled   r_mul;
    ctu_pkg::t_scaled   n_mul;
    logic               r_out_valid;
    ctu_pkg::t_out_word r_out;
    ctu_pkg::t_out_word n_out;
    logic               mul_ready;
    logic               out_ready;

    assign out_ready = !r_out_valid || i_ready;
    assign mul_ready = !r_mul_valid || out_ready;
    assign o_ready   = mul_ready;

    always_comb begin
        n_mul.ok       = i_data.ok;
        n_mul.day_secs = 33'({16'd0, i_data.days} * 33'(ctu_pkg::SecsPerDay));
        n_mul.sec_adj  = i_data.sec_adj;
    end

    always_comb begin
        n_out.valid_res = r_mul.ok;
        if (r_mul.ok) begin
            n_out.unix_seconds = signed'({1'b0, r_mul.day_secs}) + 34'(r_mul.sec_adj);
        end else begin
            n_out.unix_seconds = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mul_ready) begin
                r_mul_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_mul_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_ready && i_valid) begin
            r_mul <= n_mul;
        end
        if (out_ready && r_mul_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> rtl/ctu_checker.sv
// ============================================================================
// ctu_checker
// Port-level checks of the civil time converter, bound to the top level.
// ============================================================================
module ctu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ctu_pkg::t_out_word o_out_data
);

    // A stalled output word must hold.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // Reset empties the pipeline.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // With nothing at the output, every stage can advance, so input is open.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // A rejected timestamp reads zero. An accepted one is at least the epoch
    // minus the largest zone offset that the 7-bit offset fields can carry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.valid_res
            ? (o_out_data.unix_seconds >= -34'sd464820)
            : (o_out_data.unix_seconds == '0)))
        else $error("result out of range");

endmodule

bind civil_time_to_unix_seconds ctu_checker u_ctu_checker (.*);
